// File: sv/pcf_pkg.sv
// Shared constants and the byte-wide CRC-32 update for the PNG chunk framer.
package pcf_pkg;

  localparam int TYPE_W = 32;
  localparam int LEN_W  = 31;
  localparam int BYTE_W = 8;
  localparam int CRC_W  = 32;

  localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

  // Reflected CRC-32 update over one byte, least significant bit first.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

// File: sv/pcf_item_if.sv
// Input channel of the PNG chunk framer: one item per transfer.
interface pcf_item_if;
  logic                       valid;
  logic                       ready;
  logic                       start_chunk;
  logic [pcf_pkg::TYPE_W-1:0] chunk_type;
  logic [pcf_pkg::LEN_W-1:0]  chunk_length;
  logic                       has_byte;
  logic [pcf_pkg::BYTE_W-1:0] data_byte;
  logic                       end_chunk;

  modport source (output valid, start_chunk, chunk_type, chunk_length, has_byte,
                  data_byte, end_chunk, input ready);
  modport sink   (input valid, start_chunk, chunk_type, chunk_length, has_byte,
                  data_byte, end_chunk, output ready);
endinterface

// File: sv/pcf_result_if.sv
// Output channel of the PNG chunk framer: one framed byte per transfer.
interface pcf_result_if;
  logic                       valid;
  logic                       ready;
  logic [pcf_pkg::BYTE_W-1:0] out_byte;
  logic                       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

// File: sv/png_chunk_framer_crc32_unit.sv
// PNG chunk framer: turns items into length, type, data and CRC-32 bytes.
//
//   Channel   Direction  Interface       Moves per transfer
//   -------   ---------  --------------  ---------------------------------
//   items     in         pcf_item_if     one item: start/type/length/byte/end
//   results   out        pcf_result_if   one framed byte and its last flag
//
// Each item produces 0 to 13 bytes (8 header, 1 data, 4 CRC), and the single
// output byte lane sets the rate: an item that produces n bytes holds the
// item register until all n have gone out, so data-only items flow at one per
// cycle while results is not stalled. A byte passes through the item register
// and then the output register before it is offered on results.
// Reset (rst, synchronous) empties both stages and presets the CRC to all ones.
// A stall on results freezes the output register and, through it, the item
// register; items keeps accepting as soon as the held item's last byte moves.
module png_chunk_framer_crc32_unit (
  input  logic         clk,
  input  logic         rst,
  pcf_item_if.sink     items,
  pcf_result_if.source results
);
  import pcf_pkg::*;

  // Item register: the accepted item and the position of its next byte.
  logic              hold_valid;
  logic              h_start;
  logic [TYPE_W-1:0] h_type;
  logic [LEN_W-1:0]  h_len;
  logic              h_has;
  logic [BYTE_W-1:0] h_data;
  logic              h_end;
  logic [3:0]        pos;

  // Running CRC register, kept uninverted.
  logic [CRC_W-1:0]  crc;
  logic [CRC_W-1:0]  crc_next;

  // Output register.
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  // Sequencing of the held item's bytes: header, then data, then CRC.
  logic [3:0]        hdr_cnt;
  logic [3:0]        hdr_dat_cnt;
  logic [3:0]        run_len;
  logic              in_hdr;
  logic              in_dat;
  logic              at_last;
  logic [3:0]        crc_idx;
  logic              emit;
  logic              take;
  logic              item_busy;

  logic [63:0]       hdr_word;
  logic [63:0]       hdr_shift;
  logic [BYTE_W-1:0] hdr_byte;
  logic [CRC_W-1:0]  crc_shift;
  logic [BYTE_W-1:0] crc_out_byte;
  logic [BYTE_W-1:0] byte_sel;

  assign hdr_cnt     = h_start ? 4'd8 : 4'd0;
  assign hdr_dat_cnt = hdr_cnt + {3'b000, h_has};
  assign run_len     = hdr_dat_cnt + (h_end ? 4'd4 : 4'd0);
  assign in_hdr      = pos < hdr_cnt;
  assign in_dat      = !in_hdr && (pos < hdr_dat_cnt);
  assign at_last     = pos == (run_len - 4'd1);
  assign crc_idx     = pos - hdr_dat_cnt;

  // The header is the length with a zero top bit, then the type, big-endian.
  assign hdr_word     = {1'b0, h_len, h_type};
  assign hdr_shift    = hdr_word >> {3'd7 - pos[2:0], 3'b000};
  assign hdr_byte     = hdr_shift[BYTE_W-1:0];
  assign crc_shift    = (~crc) >> {2'd3 - crc_idx[1:0], 3'b000};
  assign crc_out_byte = crc_shift[BYTE_W-1:0];

  always_comb begin
    priority if (in_hdr) begin
      byte_sel = hdr_byte;
    end else if (in_dat) begin
      byte_sel = h_data;
    end else begin
      byte_sel = crc_out_byte;
    end
  end

  // The CRC changes only when a byte is emitted: preset on the first header
  // byte, fold in the type bytes and the data byte, and preset again once the
  // last CRC byte has gone out.
  always_comb begin
    crc_next = crc;
    priority if (in_hdr) begin
      if (pos == 4'd0) begin
        crc_next = CRC_PRESET;
      end else if (pos[2]) begin
        crc_next = crc_byte(crc, hdr_byte);
      end
    end else if (in_dat) begin
      crc_next = crc_byte(crc, h_data);
    end else if (at_last) begin
      crc_next = CRC_PRESET;
    end else begin
      crc_next = crc;
    end
  end

  assign emit      = hold_valid && (!out_valid || results.ready);
  assign items.ready = !hold_valid || (emit && at_last);
  assign take      = items.valid && items.ready;
  // An item with no flag set produces nothing and is dropped at the transfer.
  assign item_busy = items.start_chunk || items.has_byte || items.end_chunk;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pos        <= 4'd0;
      crc        <= CRC_PRESET;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        crc <= crc_next;
      end
      if (take) begin
        hold_valid <= item_busy;
        pos        <= 4'd0;
      end else if (emit) begin
        pos <= pos + 4'd1;
        if (at_last) begin
          hold_valid <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      h_start <= items.start_chunk;
      h_type  <= items.chunk_type;
      h_len   <= items.chunk_length;
      h_has   <= items.has_byte;
      h_data  <= items.data_byte;
      h_end   <= items.end_chunk;
    end
    if (emit) begin
      out_byte <= byte_sel;
      out_last <= at_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.out_byte    = out_byte;
  assign results.last_of_run = out_last;

endmodule

// File: sv/pcf_checker.sv
// Port-level checks for the PNG chunk framer and their bind to the top level.
module pcf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its byte and its last flag.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // Reset empties the item register, so the input side is open at once.
  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind png_chunk_framer_crc32_unit pcf_checker u_pcf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_byte  (results.out_byte),
  .out_last  (results.last_of_run)
);

// File: tb/tb_png_chunk_framer_crc32_unit.sv
// Self-checking testbench for the PNG chunk framer: predicts framed bytes and compares them.
module tb_png_chunk_framer_crc32_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pcf_pkg::*;

  // Stimulus stops once this many items have been accepted. Past CALM_TAIL_START
  // both sides run without idling so the block is also seen at full rate.
  localparam int ITEM_TARGET      = 450;
  localparam int CALM_TAIL_START  = 370;
  // One long stall on the results side, long enough that the output register
  // and the item register both fill and the block has to drop items.ready.
  localparam int LONG_HOLD_CYCLES = 400;
  // The slowest correct stretch without any transfer is the long hold above.
  // The random idle bursts are far shorter. So this limit only trips on a hang.
  localparam int WATCHDOG_LIMIT   = 4000;
  // A byte passes through the item and output registers, so a short settle window
  // after the last expected byte is enough to catch any stray extra output.
  localparam int DRAIN_CYCLES     = 16;
  localparam int MAX_PRINTED      = 60;

  // One input item, field for field as the item channel carries it.
  typedef struct {
    logic              start_chunk;
    logic [TYPE_W-1:0] chunk_type;
    logic [LEN_W-1:0]  chunk_length;
    logic              has_byte;
    logic [BYTE_W-1:0] data_byte;
    logic              end_chunk;
  } frame_item_t;

  // One byte of the framed stream together with its end-of-item flag.
  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } framed_byte_t;

  // Keeps its own CRC register and the queue of bytes that the framed stream
  // must still produce, in order. Every accepted item is folded in by
  // note_item(). Every byte that leaves the block is checked by check_byte().
  class chunk_stream_scoreboard;
    framed_byte_t      expected_bytes[$];
    logic [CRC_W-1:0]  crc_reg;
    int unsigned       mismatches;

    function new();
      crc_reg    = CRC_PRESET;
      mismatches = 0;
    endfunction

    // Reflected CRC-32 over one byte, one input bit per step, least
    // significant bit first.
    function logic [CRC_W-1:0] fold_byte(logic [CRC_W-1:0] c_in, logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      logic             feedback;
      c = c_in;
      for (int k = 0; k < BYTE_W; k++) begin
        feedback = c[0] ^ b[k];
        c = c >> 1;
        if (feedback) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void push_byte(logic [BYTE_W-1:0] b);
      framed_byte_t fb;
      fb.out_byte    = b;
      fb.last_of_run = 1'b0;
      expected_bytes.push_back(fb);
    endfunction

    // A 32-bit word goes out most significant byte first.
    function void push_word(logic [31:0] w);
      for (int s = 3; s >= 0; s--) push_byte(w[8*s +: 8]);
    endfunction

    function void note_item(frame_item_t it);
      int unsigned count_in;
      count_in = expected_bytes.size();
      // A start always presets the CRC, which also drops any open chunk.
      if (it.start_chunk) begin
        push_word({1'b0, it.chunk_length});
        push_word(it.chunk_type);
        crc_reg = CRC_PRESET;
        for (int s = 3; s >= 0; s--) crc_reg = fold_byte(crc_reg, it.chunk_type[8*s +: 8]);
      end
      // A data byte is folded in whether or not a chunk is open.
      if (it.has_byte) begin
        push_byte(it.data_byte);
        crc_reg = fold_byte(crc_reg, it.data_byte);
      end
      if (it.end_chunk) begin
        push_word(~crc_reg);
        crc_reg = CRC_PRESET;
      end
      if (expected_bytes.size() > count_in)
        expected_bytes[expected_bytes.size()-1].last_of_run = 1'b1;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) $display("%0t ns: mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_byte(logic [BYTE_W-1:0] got_byte, logic got_last);
      framed_byte_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h arrived with nothing expected", got_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (got_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h", got_byte, want.out_byte));
        if (got_last !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
                                    got_last, want.last_of_run, want.out_byte));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  pcf_item_if   items();
  pcf_result_if results();

  png_chunk_framer_crc32_unit dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  chunk_stream_scoreboard sb = new();

  int unsigned items_sent    = 0;
  int          stuck_cycles  = 0;
  bit          idling_on     = 1'b0;
  bit          long_hold_req = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // The monitor samples at the rising edge, before any of this edge's updates
  // land, so a transfer is seen exactly when valid and ready were both high.
  always @(posedge clk) begin
    if (!rst && results.valid === 1'b1 && results.ready === 1'b1)
      sb.check_byte(results.out_byte, results.last_of_run);
  end

  // The watchdog counts consecutive cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((items.valid === 1'b1 && items.ready === 1'b1) ||
        (results.valid === 1'b1 && results.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // The receiver normally takes every byte. While idling is on, it drops ready
  // for random bursts. Once on request, it holds off for a long stretch, which it
  // counts itself while the sender keeps offering items.
  initial begin
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        results.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        results.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        results.ready <= 1'b1;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns at the edge where it transfers. Valid stays
  // high into the next item unless an idle burst is inserted first, so valid
  // never gets two assignments in the same time step.
  task automatic send_item(input frame_item_t it);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    items.valid        <= 1'b1;
    items.start_chunk  <= it.start_chunk;
    items.chunk_type   <= it.chunk_type;
    items.chunk_length <= it.chunk_length;
    items.has_byte     <= it.has_byte;
    items.data_byte    <= it.data_byte;
    items.end_chunk    <= it.end_chunk;
    @(posedge clk);
    while (items.ready !== 1'b1) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  function automatic frame_item_t build_item(logic start, logic [TYPE_W-1:0] ctype,
                                             logic [LEN_W-1:0] clen, logic has,
                                             logic [BYTE_W-1:0] b, logic fin);
    frame_item_t it;
    it.start_chunk  = start;
    it.chunk_type   = ctype;
    it.chunk_length = clen;
    it.has_byte     = has;
    it.data_byte    = b;
    it.end_chunk    = fin;
    return it;
  endfunction

  // The flags are given. Every other field is random, including fields the
  // block ignores for this item. Lengths are mostly small and sometimes full range.
  function automatic frame_item_t random_item(logic start, logic has, logic fin);
    logic [LEN_W-1:0] clen;
    clen = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom()) : LEN_W'($urandom_range(0, 64));
    return build_item(start, TYPE_W'($urandom()), clen, has,
                      BYTE_W'($urandom_range(0, 255)), fin);
  endfunction

  // The directed part covers the corners the framer has to get right. These
  // are an end with no open chunk, both right after reset and right after
  // another end, and data bytes outside any chunk. It also sends a zero-length
  // chunk in one item and an item that raises all three flags at the field
  // extremes. It then restarts an open chunk, sends items with no flags at
  // all, and ends with a chunk in two items, a header and one closing data byte.
  task automatic run_directed();
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b0, 8'h00, 1'b1));
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b1, 8'h00, 1'b0));
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b1, 8'hFF, 1'b1));
    send_item(build_item(1'b1, 32'h4948_4452, 31'd13, 1'b0, 8'h00, 1'b0));
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b1, 8'h00, 1'b0));
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b1, 8'hFF, 1'b0));
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b1, 8'hA5, 1'b0));
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b1, 8'h5A, 1'b1));
    // IEND: the twelve bytes end in the well-known CRC AE 42 60 82.
    send_item(build_item(1'b1, 32'h4945_4E44, 31'd0, 1'b0, 8'h00, 1'b1));
    send_item(build_item(1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 8'hFF, 1'b1));
    send_item(build_item(1'b1, 32'h0000_0000, 31'd0, 1'b1, 8'h00, 1'b0));
    send_item(build_item(1'b1, 32'h4944_4154, 31'd5, 1'b0, 8'h00, 1'b0));
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b1, 8'h80, 1'b1));
    send_item(build_item(1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 8'hFF, 1'b0));
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b0, 8'h00, 1'b0));
    send_item(build_item(1'b1, 32'h7445_5874, 31'd1, 1'b1, 8'h41, 1'b1));
    send_item(build_item(1'b0, 32'h0, 31'h0, 1'b0, 8'h00, 1'b1));
    send_item(build_item(1'b1, 32'h5555_5555, 31'h2AAA_AAAA, 1'b0, 8'h55, 1'b0));
    send_item(build_item(1'b0, 32'hAAAA_AAAA, 31'h5555_5555, 1'b1, 8'hAA, 1'b1));
  endtask

  // A well-formed chunk is one start item, some data items and a closing end.
  // The end may ride on the header or on the last data item. A truncated
  // chunk never closes, so the next start must abandon it.
  task automatic send_chunk(input bit truncated);
    int          n_data;
    frame_item_t it;
    n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 6);
    it = random_item(1'b1, 1'($urandom_range(0, 1)), 1'b0);
    if (!truncated && n_data == 0 && $urandom_range(0, 1) == 1) it.end_chunk = 1'b1;
    send_item(it);
    for (int i = 0; i < n_data; i++) begin
      it = random_item(1'b0, 1'b1, 1'b0);
      if (!truncated && i == n_data - 1 && $urandom_range(0, 1) == 1) it.end_chunk = 1'b1;
      send_item(it);
    end
    if (!truncated && !it.end_chunk)
      send_item(random_item(1'b0, 1'($urandom_range(0, 1)), 1'b1));
  endtask

  // Most of the random part is well-formed chunks. About one pick in ten is
  // loose noise with random flags, and about one in ten is a truncated chunk.
  // Idling is turned on and off per pick, which leaves stretches without gaps.
  // The tail runs with no idling at all.
  task automatic run_random();
    int pick;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_TAIL_START) idling_on = 1'b0;
      else idling_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(random_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1))));
      end else begin
        send_chunk(pick == 1);
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    items.valid        <= 1'b0;
    items.start_chunk  <= 1'b0;
    items.chunk_type   <= '0;
    items.chunk_length <= '0;
    items.has_byte     <= 1'b0;
    items.data_byte    <= '0;
    items.end_chunk    <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Start the long receiver hold. The random stimulus that follows keeps
    // offering items, so the block fills and has to stall its input.
    long_hold_req = 1'b1;
    run_random();
    items.valid <= 1'b0;

    // Drain everything still owed, then give the block time to show any
    // byte that it should not have produced.
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
